// ===== src/cir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cir_pkg;

	localparam int COMP_W = 20;
	localparam int VEC_W = 3 * COMP_W;
	localparam int IM_W = 24;
	localparam int TOT_W = IM_W + 1;
	localparam int PEN_W = 19;
	localparam int REST_W = 17;
	localparam int SUM_W = 24;

	localparam int NUM_W = 69;
	localparam int Q_W = 22;
	localparam int REM_W = TOT_W;
	localparam int DIV_BITS = 2;
	localparam int DIV_STAGES = Q_W / DIV_BITS;
	localparam int LANES = 12;

	localparam int LANE_PA = 0;
	localparam int LANE_PB = 1;
	localparam int LANE_JA = 2;
	localparam int LANE_JB = 3;

	localparam logic [Q_W-1:0] MAG_CAP = 22'h200000;

	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_SEPARATING = 2'd1,
		OUT_IMPULSE = 2'd2
	} outcome_t;

	typedef logic [LANES-1:0][NUM_W-1:0] num_vec_t;
	typedef logic [LANES-1:0][Q_W-1:0] mag_vec_t;

	typedef struct packed {
		logic [VEC_W-1:0] va;
		logic [VEC_W-1:0] vb;
		logic [2:0] nneg;
		logic tot_zero;
		logic sep;
	} side_t;

endpackage

`default_nettype wire

// ===== src/contact_impulse_resolver_core.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    inverse masses, velocities, normal, depth, restitutions
// out      output     out_valid / out_stall  position deltas, new velocities, outcome
//
// One item is taken per cycle while in_stall is low.
// Each item passes through six arithmetic stages, twelve divider stages and the output register.
// The first divider stage checks for overflow; each of the other eleven retires two
// quotient bits for twelve lanes in parallel.
// Reset clears all valid bits; payload registers are not reset.
// Each stage holds while the next one is full and stalled, so empty stages still fill.
`timescale 1ns / 1ps
`default_nettype none

module contact_impulse_resolver_core import cir_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [IM_W-1:0] inv_mass_a,
	input logic [IM_W-1:0] inv_mass_b,
	input logic [VEC_W-1:0] velocity_a,
	input logic [VEC_W-1:0] velocity_b,
	input logic [VEC_W-1:0] normal_vector,
	input logic [PEN_W-1:0] penetration,
	input logic [REST_W-1:0] restitution_a,
	input logic [REST_W-1:0] restitution_b,
	output logic out_valid,
	input logic out_stall,
	output logic [VEC_W-1:0] position_delta_a,
	output logic [VEC_W-1:0] position_delta_b,
	output logic [VEC_W-1:0] new_velocity_a,
	output logic [VEC_W-1:0] new_velocity_b,
	output logic [1:0] outcome
);

	logic front_ready, front_valid;
	num_vec_t front_num;
	logic [TOT_W-1:0] front_total;
	side_t front_side;
	logic div_ready, div_valid;
	mag_vec_t div_mag;
	side_t div_side;
	logic back_ready;

	assign in_stall = !front_ready;

	cir_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(front_ready),
		.inv_mass_a(inv_mass_a),
		.inv_mass_b(inv_mass_b),
		.velocity_a(velocity_a),
		.velocity_b(velocity_b),
		.normal_vector(normal_vector),
		.penetration(penetration),
		.restitution_a(restitution_a),
		.restitution_b(restitution_b),
		.out_valid(front_valid),
		.out_ready(div_ready),
		.num(front_num),
		.total(front_total),
		.side(front_side)
	);

	cir_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(front_valid),
		.in_ready(div_ready),
		.num(front_num),
		.total(front_total),
		.side(front_side),
		.out_valid(div_valid),
		.out_ready(back_ready),
		.mag(div_mag),
		.side_o(div_side)
	);

	cir_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_valid),
		.in_ready(back_ready),
		.mag(div_mag),
		.side(div_side),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position_delta_a(position_delta_a),
		.position_delta_b(position_delta_b),
		.new_velocity_a(new_velocity_a),
		.new_velocity_b(new_velocity_b),
		.outcome(outcome)
	);

endmodule

`default_nettype wire

// ===== src/cir_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_front import cir_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [IM_W-1:0] inv_mass_a,
	input logic [IM_W-1:0] inv_mass_b,
	input logic [VEC_W-1:0] velocity_a,
	input logic [VEC_W-1:0] velocity_b,
	input logic [VEC_W-1:0] normal_vector,
	input logic [PEN_W-1:0] penetration,
	input logic [REST_W-1:0] restitution_a,
	input logic [REST_W-1:0] restitution_b,
	output logic out_valid,
	input logic out_ready,
	output num_vec_t num,
	output logic [TOT_W-1:0] total,
	output side_t side
);

	localparam int NM_W = COMP_W;
	localparam int F_W = 19;
	localparam int NP_W = NM_W + PEN_W;
	localparam int PA_W = NP_W + IM_W;
	localparam int DV_W = COMP_W + 1;
	localparam int DP_W = DV_W + COMP_W;
	localparam int VN_W = DP_W + 2;
	localparam int MVN_W = 42;
	localparam int PLO_W = 32;
	localparam int PHI_W = PA_W - PLO_W;
	localparam int MLO_W = 21;
	localparam int MHI_W = MVN_W - MLO_W;
	localparam int PP_W = PLO_W + MLO_W;
	localparam int VNUM_W = PA_W + MVN_W;
	localparam int POS_SH = 10;
	localparam int VEL_SH = 37;
	localparam int POSN_W = PA_W + 1 - POS_SH;
	localparam logic [F_W-1:0] F_ONE = 19'd131072;

	logic en1, en2, en3, en4, en5, en6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign en6 = !vld_s6 || out_ready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: unpack, normal magnitudes, first products.
	logic [F_W-1:0] f_c;
	logic [NM_W-1:0] nm_c [3];
	logic signed [COMP_W-1:0] n_c [3];
	logic signed [DV_W-1:0] dv_c [3];
	logic [NP_W-1:0] np_c [3];
	logic [NP_W-1:0] nf_c [3];

	always_comb begin
		f_c = F_ONE + F_W'(restitution_a) + F_W'(restitution_b);
		for (int c = 0; c < 3; c++) begin
			n_c[c] = $signed(normal_vector[c*COMP_W +: COMP_W]);
			nm_c[c] = n_c[c][COMP_W-1] ? (~normal_vector[c*COMP_W +: COMP_W] + 1'b1)
				: normal_vector[c*COMP_W +: COMP_W];
			dv_c[c] = $signed({velocity_b[c*COMP_W+COMP_W-1], velocity_b[c*COMP_W +: COMP_W]})
				- $signed({velocity_a[c*COMP_W+COMP_W-1], velocity_a[c*COMP_W +: COMP_W]});
			np_c[c] = NP_W'(nm_c[c]) * NP_W'(penetration);
			nf_c[c] = NP_W'(nm_c[c]) * NP_W'(f_c);
		end
	end

	logic [IM_W-1:0] ima_s1, imb_s1;
	logic [TOT_W-1:0] total_s1;
	logic signed [COMP_W-1:0] n_s1 [3];
	logic signed [DV_W-1:0] dv_s1 [3];
	logic [NP_W-1:0] np_s1 [3];
	logic [NP_W-1:0] nf_s1 [3];
	logic [VEC_W-1:0] va_s1, vb_s1;
	logic [2:0] nneg_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ima_s1 <= inv_mass_a;
			imb_s1 <= inv_mass_b;
			total_s1 <= TOT_W'(inv_mass_a) + TOT_W'(inv_mass_b);
			va_s1 <= velocity_a;
			vb_s1 <= velocity_b;
			for (int c = 0; c < 3; c++) begin
				n_s1[c] <= n_c[c];
				dv_s1[c] <= dv_c[c];
				np_s1[c] <= np_c[c];
				nf_s1[c] <= nf_c[c];
				nneg_s1[c] <= n_c[c][COMP_W-1];
			end
		end
	end

	// Stage 2: products with the inverse masses and the dot product terms.
	logic [PA_W-1:0] pv_s2 [6];
	logic [PA_W-1:0] nfv_s2 [6];
	logic signed [DP_W-1:0] dp_s2 [3];
	logic [TOT_W-1:0] total_s2;
	logic [VEC_W-1:0] va_s2, vb_s2;
	logic [2:0] nneg_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			total_s2 <= total_s1;
			va_s2 <= va_s1;
			vb_s2 <= vb_s1;
			nneg_s2 <= nneg_s1;
			for (int c = 0; c < 3; c++) begin
				pv_s2[c*2] <= PA_W'(np_s1[c]) * PA_W'(ima_s1);
				pv_s2[c*2+1] <= PA_W'(np_s1[c]) * PA_W'(imb_s1);
				nfv_s2[c*2] <= PA_W'(nf_s1[c]) * PA_W'(ima_s1);
				nfv_s2[c*2+1] <= PA_W'(nf_s1[c]) * PA_W'(imb_s1);
				dp_s2[c] <= $signed({{COMP_W{dv_s1[c][DV_W-1]}}, dv_s1[c]})
					* $signed({{DV_W{n_s1[c][COMP_W-1]}}, n_s1[c]});
			end
		end
	end

	// Stage 3: normal velocity, separation test, position numerators.
	logic signed [VN_W-1:0] vn_c;
	logic sep_c;
	logic [VN_W-1:0] mvn_full;
	logic [PA_W:0] pt_c [6];

	always_comb begin
		vn_c = VN_W'(dp_s2[0]) + VN_W'(dp_s2[1]) + VN_W'(dp_s2[2]);
		sep_c = !vn_c[VN_W-1] && (vn_c != '0);
		mvn_full = sep_c ? '0 : (~vn_c + 1'b1);
		for (int l = 0; l < 6; l++) begin
			pt_c[l] = (PA_W+1)'(pv_s2[l]) + ((PA_W+1)'(total_s2) << (POS_SH - 1));
		end
	end

	logic [POSN_W-1:0] posn_s3 [6];
	logic [PA_W-1:0] nfv_s3 [6];
	logic [MVN_W-1:0] mvn_s3;
	logic [TOT_W-1:0] total_s3;
	side_t side_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			mvn_s3 <= mvn_full[MVN_W-1:0];
			total_s3 <= total_s2;
			side_s3 <= '{va: va_s2, vb: vb_s2, nneg: nneg_s2,
				tot_zero: (total_s2 == '0), sep: sep_c};
			for (int l = 0; l < 6; l++) begin
				posn_s3[l] <= pt_c[l][PA_W:POS_SH];
				nfv_s3[l] <= nfv_s2[l];
			end
		end
	end

	// Stage 4: partial products of the impulse numerators.
	logic [PP_W-1:0] pp_s4 [6][4];
	logic [POSN_W-1:0] posn_s4 [6];
	logic [TOT_W-1:0] total_s4;
	side_t side_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			total_s4 <= total_s3;
			side_s4 <= side_s3;
			for (int l = 0; l < 6; l++) begin
				posn_s4[l] <= posn_s3[l];
				pp_s4[l][0] <= PP_W'(nfv_s3[l][PLO_W-1:0]) * PP_W'(mvn_s3[MLO_W-1:0]);
				pp_s4[l][1] <= PP_W'(nfv_s3[l][PLO_W-1:0]) * PP_W'(mvn_s3[MVN_W-1:MLO_W]);
				pp_s4[l][2] <= PP_W'(nfv_s3[l][PA_W-1:PLO_W]) * PP_W'(mvn_s3[MLO_W-1:0]);
				pp_s4[l][3] <= PP_W'(nfv_s3[l][PA_W-1:PLO_W])
					* PP_W'(mvn_s3[MVN_W-1:MLO_W]);
			end
		end
	end

	// Stage 5: sum of the partial products.
	logic [VNUM_W-1:0] vnum_s5 [6];
	logic [POSN_W-1:0] posn_s5 [6];
	logic [TOT_W-1:0] total_s5;
	side_t side_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			total_s5 <= total_s4;
			side_s5 <= side_s4;
			for (int l = 0; l < 6; l++) begin
				posn_s5[l] <= posn_s4[l];
				vnum_s5[l] <= VNUM_W'(pp_s4[l][0])
					+ (VNUM_W'(pp_s4[l][1]) << MLO_W)
					+ (VNUM_W'(pp_s4[l][2]) << PLO_W)
					+ (VNUM_W'(pp_s4[l][3]) << (PLO_W + MHI_W - MHI_W + MLO_W));
			end
		end
	end

	// Stage 6: rounding offset and scaling of the impulse numerators.
	logic [VNUM_W:0] vt_c [6];

	always_comb begin
		for (int l = 0; l < 6; l++) begin
			vt_c[l] = (VNUM_W+1)'(vnum_s5[l]) + ((VNUM_W+1)'(total_s5) << (VEL_SH - 1));
		end
	end

	num_vec_t num_s6;
	logic [TOT_W-1:0] total_s6;
	side_t side_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			total_s6 <= total_s5;
			side_s6 <= side_s5;
			for (int c = 0; c < 3; c++) begin
				num_s6[c*4+LANE_PA] <= NUM_W'(posn_s5[c*2]);
				num_s6[c*4+LANE_PB] <= NUM_W'(posn_s5[c*2+1]);
				num_s6[c*4+LANE_JA] <= vt_c[c*2][VNUM_W:VEL_SH];
				num_s6[c*4+LANE_JB] <= vt_c[c*2+1][VNUM_W:VEL_SH];
			end
		end
	end

	assign out_valid = vld_s6;
	assign num = num_s6;
	assign total = total_s6;
	assign side = side_s6;

endmodule

`default_nettype wire

// ===== src/cir_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_div import cir_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input num_vec_t num,
	input logic [TOT_W-1:0] total,
	input side_t side,
	output logic out_valid,
	input logic out_ready,
	output mag_vec_t mag,
	output side_t side_o
);

	logic [DIV_STAGES:0] vld_s;
	logic [DIV_STAGES:0] en;
	logic [LANES-1:0][REM_W-1:0] rem_s [DIV_STAGES+1];
	logic [LANES-1:0][Q_W-1:0] low_s [DIV_STAGES+1];
	logic [LANES-1:0][Q_W-1:0] quo_s [DIV_STAGES+1];
	logic [LANES-1:0] ovf_s [DIV_STAGES+1];
	logic [TOT_W-1:0] total_s [DIV_STAGES+1];
	side_t side_s [DIV_STAGES+1];

	logic [LANES-1:0][REM_W-1:0] rem_n [DIV_STAGES+1];
	logic [LANES-1:0][Q_W-1:0] low_n [DIV_STAGES+1];
	logic [LANES-1:0][Q_W-1:0] quo_n [DIV_STAGES+1];
	logic [LANES-1:0] ovf_n;

	always_comb begin
		en[DIV_STAGES] = !vld_s[DIV_STAGES] || out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_comb begin
		logic [REM_W:0] trial;
		logic [REM_W-1:0] r;
		logic [Q_W-1:0] lo;
		logic [Q_W-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			ovf_n[l] = num[l] >= (NUM_W'(total) << Q_W);
			rem_n[0][l] = ovf_n[l] ? '0 : num[l][Q_W+REM_W-1:Q_W];
			low_n[0][l] = num[l][Q_W-1:0];
			quo_n[0][l] = '0;
		end
		for (int k = 1; k <= DIV_STAGES; k++) begin
			for (int l = 0; l < LANES; l++) begin
				r = rem_s[k-1][l];
				lo = low_s[k-1][l];
				q = quo_s[k-1][l];
				for (int b = 0; b < DIV_BITS; b++) begin
					trial = {r, lo[Q_W-1]};
					lo = {lo[Q_W-2:0], 1'b0};
					if (trial >= {1'b0, total_s[k-1]}) begin
						trial = trial - {1'b0, total_s[k-1]};
						q = {q[Q_W-2:0], 1'b1};
					end else begin
						q = {q[Q_W-2:0], 1'b0};
					end
					r = trial[REM_W-1:0];
				end
				rem_n[k][l] = r;
				low_n[k][l] = lo;
				quo_n[k][l] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= in_valid;
			for (int k = 1; k <= DIV_STAGES; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= rem_n[0];
			low_s[0] <= low_n[0];
			quo_s[0] <= quo_n[0];
			ovf_s[0] <= ovf_n;
			total_s[0] <= total;
			side_s[0] <= side;
		end
		for (int k = 1; k <= DIV_STAGES; k++) begin
			if (en[k]) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_n[k];
				quo_s[k] <= quo_n[k];
				ovf_s[k] <= ovf_s[k-1];
				total_s[k] <= total_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag[l] = (ovf_s[DIV_STAGES][l] || (quo_s[DIV_STAGES][l] > MAG_CAP))
				? MAG_CAP : quo_s[DIV_STAGES][l];
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign side_o = side_s[DIV_STAGES];

endmodule

`default_nettype wire

// ===== src/cir_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_back import cir_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mag_vec_t mag,
	input side_t side,
	output logic out_valid,
	input logic out_stall,
	output logic [VEC_W-1:0] position_delta_a,
	output logic [VEC_W-1:0] position_delta_b,
	output logic [VEC_W-1:0] new_velocity_a,
	output logic [VEC_W-1:0] new_velocity_b,
	output logic [1:0] outcome
);

	function automatic logic [COMP_W-1:0] sat_comp(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-COMP_W:0] top;
		top = x[SUM_W-1:COMP_W-1];
		if ((&top) || !(|top)) begin
			return x[COMP_W-1:0];
		end
		return x[SUM_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
	endfunction

	logic en;
	logic vld_q;
	logic [VEC_W-1:0] pda_c, pdb_c, nva_c, nvb_c;
	outcome_t oc_c;

	assign en = !vld_q || !out_stall;
	assign in_ready = en;

	always_comb begin
		logic signed [SUM_W-1:0] ma, mb, ja, jb, va, vb, da, db;
		logic impulse;
		impulse = !side.tot_zero && !side.sep;
		for (int c = 0; c < 3; c++) begin
			ma = $signed({2'b00, mag[c*4+LANE_PA]});
			mb = $signed({2'b00, mag[c*4+LANE_PB]});
			ja = $signed({2'b00, mag[c*4+LANE_JA]});
			jb = $signed({2'b00, mag[c*4+LANE_JB]});
			va = $signed({{(SUM_W-COMP_W){side.va[c*COMP_W+COMP_W-1]}},
				side.va[c*COMP_W +: COMP_W]});
			vb = $signed({{(SUM_W-COMP_W){side.vb[c*COMP_W+COMP_W-1]}},
				side.vb[c*COMP_W +: COMP_W]});
			if (side.tot_zero) begin
				da = '0;
				db = '0;
			end else begin
				da = side.nneg[c] ? ma : -ma;
				db = side.nneg[c] ? -mb : mb;
			end
			if (impulse) begin
				va = side.nneg[c] ? va + ja : va - ja;
				vb = side.nneg[c] ? vb - jb : vb + jb;
			end
			pda_c[c*COMP_W +: COMP_W] = sat_comp(da);
			pdb_c[c*COMP_W +: COMP_W] = sat_comp(db);
			nva_c[c*COMP_W +: COMP_W] = sat_comp(va);
			nvb_c[c*COMP_W +: COMP_W] = sat_comp(vb);
		end
		if (side.tot_zero) begin
			oc_c = OUT_NONE;
		end else if (side.sep) begin
			oc_c = OUT_SEPARATING;
		end else begin
			oc_c = OUT_IMPULSE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			position_delta_a <= pda_c;
			position_delta_b <= pdb_c;
			new_velocity_a <= nva_c;
			new_velocity_b <= nvb_c;
			outcome <= oc_c;
		end
	end

	assign out_valid = vld_q;

endmodule

`default_nettype wire

// ===== src/cir_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_checker import cir_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [VEC_W-1:0] position_delta_a,
	input logic [VEC_W-1:0] position_delta_b,
	input logic [VEC_W-1:0] new_velocity_a,
	input logic [1:0] outcome
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_velocity_a)
			&& $stable(outcome))
		else $error("stalled result item changed");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OUT_NONE) || (outcome == OUT_SEPARATING)
			|| (outcome == OUT_IMPULSE))
		else $error("unknown outcome code");

	a_no_body_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_NONE) |-> (position_delta_a == '0)
			&& (position_delta_b == '0))
		else $error("position delta without a movable body");

endmodule

bind contact_impulse_resolver_core cir_checker u_cir_checker (.*);

`default_nettype wire

// ===== test/contact_impulse_resolver_core_tb.sv =====
`timescale 1ns / 1ps

module contact_impulse_resolver_core_tb;
	import cir_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint ONE_Q10 = 1024;

	typedef struct {
		logic [IM_W-1:0] ima;
		logic [IM_W-1:0] imb;
		logic [VEC_W-1:0] va;
		logic [VEC_W-1:0] vb;
		logic [VEC_W-1:0] nrm;
		logic [PEN_W-1:0] pen;
		logic [REST_W-1:0] ra;
		logic [REST_W-1:0] rb;
	} contact_t;

	typedef struct {
		logic [VEC_W-1:0] dpa;
		logic [VEC_W-1:0] dpb;
		logic [VEC_W-1:0] nva;
		logic [VEC_W-1:0] nvb;
		outcome_t oc;
	} resolution_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [IM_W-1:0] inv_mass_a;
	logic [IM_W-1:0] inv_mass_b;
	logic [VEC_W-1:0] velocity_a;
	logic [VEC_W-1:0] velocity_b;
	logic [VEC_W-1:0] normal_vector;
	logic [PEN_W-1:0] penetration;
	logic [REST_W-1:0] restitution_a;
	logic [REST_W-1:0] restitution_b;
	logic out_valid;
	logic out_stall;
	logic [VEC_W-1:0] position_delta_a;
	logic [VEC_W-1:0] position_delta_b;
	logic [VEC_W-1:0] new_velocity_a;
	logic [VEC_W-1:0] new_velocity_b;
	logic [1:0] outcome;

	resolution_t pending_resolutions[$];
	int mismatches;
	int idle_cycles;
	bit stall_quiet;

	contact_impulse_resolver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.inv_mass_a(inv_mass_a),
		.inv_mass_b(inv_mass_b),
		.velocity_a(velocity_a),
		.velocity_b(velocity_b),
		.normal_vector(normal_vector),
		.penetration(penetration),
		.restitution_a(restitution_a),
		.restitution_b(restitution_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position_delta_a(position_delta_a),
		.position_delta_b(position_delta_b),
		.new_velocity_a(new_velocity_a),
		.new_velocity_b(new_velocity_b),
		.outcome(outcome)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint comp_of(logic [VEC_W-1:0] v, int c);
		logic signed [COMP_W-1:0] s;
		s = v[COMP_W*c +: COMP_W];
		return longint'(s);
	endfunction

	function automatic logic [VEC_W-1:0] pack_saturated(longint x, longint y, longint z);
		longint w[3];
		logic [VEC_W-1:0] r;
		w[0] = x;
		w[1] = y;
		w[2] = z;
		r = '0;
		for (int c = 0; c < 3; c++) begin
			if (w[c] > 524287)
				w[c] = 524287;
			else if (w[c] < -524288)
				w[c] = -524288;
			r[COMP_W*c +: COMP_W] = w[c][COMP_W-1:0];
		end
		return r;
	endfunction

	function automatic longint rounded_quotient(logic [127:0] num, logic [127:0] den);
		logic [127:0] q;
		q = (num + (den >> 1)) / den;
		if (q > 128'(MAG_CAP))
			q = 128'(MAG_CAP);
		return longint'(q[63:0]);
	endfunction

	function automatic resolution_t resolve_contact(contact_t k);
		resolution_t r;
		longint va[3], vb[3], n[3], da[3], db[3];
		logic [127:0] nm[3];
		logic [127:0] total, fac, mvn;
		longint vn, ma, mb;
		total = 128'(k.ima) + 128'(k.imb);
		vn = 0;
		for (int c = 0; c < 3; c++) begin
			va[c] = comp_of(k.va, c);
			vb[c] = comp_of(k.vb, c);
			n[c] = comp_of(k.nrm, c);
			nm[c] = 128'(n[c] < 0 ? -n[c] : n[c]);
			da[c] = 0;
			db[c] = 0;
		end
		if (total == 0) begin
			r.oc = OUT_NONE;
		end else begin
			for (int c = 0; c < 3; c++) begin
				ma = rounded_quotient(nm[c] * 128'(k.pen) * 128'(k.ima), total << 10);
				mb = rounded_quotient(nm[c] * 128'(k.pen) * 128'(k.imb), total << 10);
				da[c] = (n[c] < 0) ? ma : -ma;
				db[c] = (n[c] < 0) ? -mb : mb;
				vn += (vb[c] - va[c]) * n[c];
			end
			if (vn > 0) begin
				r.oc = OUT_SEPARATING;
			end else begin
				r.oc = OUT_IMPULSE;
				mvn = 128'(-vn);
				fac = 128'(131072) + 128'(k.ra) + 128'(k.rb);
				for (int c = 0; c < 3; c++) begin
					ma = rounded_quotient(nm[c] * fac * 128'(k.ima) * mvn, total << 37);
					mb = rounded_quotient(nm[c] * fac * 128'(k.imb) * mvn, total << 37);
					if (n[c] < 0) begin
						va[c] += ma;
						vb[c] -= mb;
					end else begin
						va[c] -= ma;
						vb[c] += mb;
					end
				end
			end
		end
		r.dpa = pack_saturated(da[0], da[1], da[2]);
		r.dpb = pack_saturated(db[0], db[1], db[2]);
		r.nva = pack_saturated(va[0], va[1], va[2]);
		r.nvb = pack_saturated(vb[0], vb[1], vb[2]);
		return r;
	endfunction

	function automatic logic [VEC_W-1:0] vec3(longint x, longint y, longint z);
		return {z[COMP_W-1:0], y[COMP_W-1:0], x[COMP_W-1:0]};
	endfunction

	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_contact(contact_t k, bit with_gaps);
		int gap;
		@(negedge clk);
		inv_mass_a = k.ima;
		inv_mass_b = k.imb;
		velocity_a = k.va;
		velocity_b = k.vb;
		normal_vector = k.nrm;
		penetration = k.pen;
		restitution_a = k.ra;
		restitution_b = k.rb;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_resolutions = {pending_resolutions, resolve_contact(k)};
		gap = with_gaps ? random_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_resolutions.size() != 0)
			@(posedge clk);
	endtask

	function automatic contact_t make_contact(longint ima, longint imb, logic [VEC_W-1:0] va,
			logic [VEC_W-1:0] vb, logic [VEC_W-1:0] nrm, longint pen, longint ra, longint rb);
		contact_t k;
		k.ima = ima[IM_W-1:0];
		k.imb = imb[IM_W-1:0];
		k.va = va;
		k.vb = vb;
		k.nrm = nrm;
		k.pen = pen[PEN_W-1:0];
		k.ra = ra[REST_W-1:0];
		k.rb = rb[REST_W-1:0];
		return k;
	endfunction

	task automatic test_field_extremes();
		logic [VEC_W-1:0] vmax, vmin, nx;
		vmax = vec3(524287, 524287, 524287);
		vmin = vec3(-524288, -524288, -524288);
		nx = vec3(ONE_Q10, 0, 0);
		send_contact(make_contact(0, 0, '0, '0, nx, 0, 0, 0), 0);
		send_contact(make_contact(24'hFFFFFF, 24'hFFFFFF, vmax, vmin, vmin, 19'h7FFFF,
			65536, 65536), 0);
		send_contact(make_contact(24'hFFFFFF, 0, vmin, vmax, vmax, 19'h7FFFF, 65536, 0), 0);
		send_contact(make_contact(0, 24'hFFFFFF, vmax, vmin, vmax, 19'h7FFFF, 0, 65536), 0);
		send_contact(make_contact(1, 1, vmax, vmin, vec3(-524288, 524287, -1), 1, 1, 1), 0);
		send_contact(make_contact(65536, 65536, {VEC_W{1'b1}}, {VEC_W{1'b1}},
			{VEC_W{1'b1}}, 19'h7FFFF, 65535, 65535), 0);
	endtask

	task automatic test_special_cases();
		logic [VEC_W-1:0] nx, ny;
		nx = vec3(ONE_Q10, 0, 0);
		ny = vec3(0, -ONE_Q10, 0);
		// No movable body: velocities pass through and deltas are zero.
		send_contact(make_contact(0, 0, vec3(5000, -7000, 9), vec3(-3, 4, 5), nx, 4096,
			65536, 65536), 0);
		// Separating along the normal.
		send_contact(make_contact(65536, 65536, vec3(-2048, 0, 0), vec3(2048, 0, 0), nx,
			512, 32768, 32768), 0);
		// Zero normal velocity still resolves with a zero impulse.
		send_contact(make_contact(65536, 131072, vec3(1000, 77, 0), vec3(1000, -50, 0), nx,
			300, 0, 0), 0);
		// Approaching bodies, one immovable.
		send_contact(make_contact(0, 65536, vec3(0, 0, 0), vec3(0, 3072, 0), ny, 700,
			65536, 65536), 0);
		// Approaching with full restitution on both sides.
		send_contact(make_contact(65536, 65536, vec3(4096, 0, 0), vec3(-4096, 0, 0), nx,
			1024, 65536, 65536), 0);
		// A normal that is not of unit length, and a zero normal.
		send_contact(make_contact(30000, 9000, vec3(100, 200, 300), vec3(-400, -500, -600),
			vec3(3000, -2500, 7000), 2000, 40000, 1), 0);
		send_contact(make_contact(30000, 9000, vec3(100, 200, 300), vec3(-400, -500, -600),
			'0, 2000, 40000, 1), 0);
		// Large closing speed drives the new velocities into saturation.
		send_contact(make_contact(24'hFFFFFF, 24'hFFFFFF, vec3(524287, 0, 0),
			vec3(-524288, 0, 0), vec3(524287, 0, 0), 0, 65536, 65536), 0);
	endtask

	function automatic longint random_comp(int wide);
		if (wide != 0)
			return longint'($signed(20'($urandom)));
		return longint'($urandom_range(0, 16384)) - 8192;
	endfunction

	function automatic logic [VEC_W-1:0] random_normal();
		int p;
		p = $urandom_range(0, 9);
		if (p < 6) begin
			case ($urandom_range(0, 2))
				0: return vec3($urandom_range(0, 1) ? ONE_Q10 : -ONE_Q10, 0, 0);
				1: return vec3(0, $urandom_range(0, 1) ? ONE_Q10 : -ONE_Q10, 0);
				default: return vec3(591, -591, $urandom_range(0, 1) ? 591 : -591);
			endcase
		end
		if (p < 9)
			return vec3(random_comp(0) / 8, random_comp(0) / 8, random_comp(0) / 8);
		return VEC_W'({$urandom, $urandom});
	endfunction

	function automatic logic [IM_W-1:0] random_inv_mass();
		case ($urandom_range(0, 9))
			0, 1: return '0;
			2: return 24'hFFFFFF;
			3, 4: return IM_W'($urandom);
			default: return IM_W'($urandom_range(1024, 262144));
		endcase
	endfunction

	function automatic logic [REST_W-1:0] random_restitution();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return REST_W'(65536);
			default: return REST_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic test_random_contacts(int count);
		contact_t k;
		int wide;
		for (int i = 0; i < count; i++) begin
			wide = ($urandom_range(0, 4) == 0);
			k.ima = random_inv_mass();
			k.imb = random_inv_mass();
			k.va = vec3(random_comp(wide), random_comp(wide), random_comp(wide));
			k.vb = vec3(random_comp(wide), random_comp(wide), random_comp(wide));
			k.nrm = random_normal();
			k.pen = ($urandom_range(0, 3) == 0) ? PEN_W'($urandom) :
				PEN_W'($urandom_range(0, 4096));
			k.ra = random_restitution();
			k.rb = random_restitution();
			send_contact(k, i % 150 < 120);
		end
	endtask

	task automatic test_pause_until_drained();
		test_random_contacts(30);
		wait_for_drain();
		test_random_contacts(30);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		inv_mass_a = '0;
		inv_mass_b = '0;
		velocity_a = '0;
		velocity_b = '0;
		normal_vector = '0;
		penetration = '0;
		restitution_a = '0;
		restitution_b = '0;
		mismatches = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_field_extremes();
		test_special_cases();
		test_random_contacts(280);
		test_pause_until_drained();
		test_random_contacts(250);
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_resolutions.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		stall_quiet = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) == 0)
				stall_quiet = ~stall_quiet;
			if (stall_quiet || !arst_n)
				out_stall = 1'b0;
			else if ($urandom_range(0, 199) == 0)
				out_stall = 1'b1;
			else if (out_stall)
				out_stall = ($urandom_range(0, 9) < 7);
			else
				out_stall = ($urandom_range(0, 9) < 2);
		end
	end

	always @(posedge clk) begin
		resolution_t want;
		if (out_valid && !out_stall) begin
			if (pending_resolutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item at %0t", $realtime);
			end else begin
				want = pending_resolutions.pop_front();
				if (position_delta_a !== want.dpa || position_delta_b !== want.dpb ||
						new_velocity_a !== want.nva || new_velocity_b !== want.nvb ||
						outcome !== want.oc) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at %0t", $realtime);
						$display("  dpa exp %h got %h", want.dpa, position_delta_a);
						$display("  dpb exp %h got %h", want.dpb, position_delta_b);
						$display("  nva exp %h got %h", want.nva, new_velocity_a);
						$display("  nvb exp %h got %h", want.nvb, new_velocity_b);
						$display("  outcome exp %0d got %0d", want.oc, outcome);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
src/cir_pkg.sv
src/cir_front.sv
src/cir_div.sv
src/cir_back.sv
src/contact_impulse_resolver_core.sv
src/cir_checker.sv
test/contact_impulse_resolver_core_tb.sv
